// ===== hw/rtl/ftb_pkg.sv =====
// Package for the feature track builder: sizes, status codes, sequencer states,
// and shared types. No dependencies.
`timescale 1ns / 1ps
package ftb_pkg;
	localparam int MAX_TRACKS = 1024;
	localparam int MAX_VIEWS  = 16;
	localparam int IMAGE_BITS = 8;
	localparam int POINT_BITS = 16;

	typedef enum logic [2:0] {
		ST_APPENDED = 3'd0,
		ST_REPEAT   = 3'd1,
		ST_CONFLICT = 3'd2,
		ST_IGNORED  = 3'd3,
		ST_NEW      = 3'd4,
		ST_VFULL    = 3'd5,
		ST_TFULL    = 3'd6,
		ST_READ     = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RDREQ, S_RDWAIT, S_RDOUT,
		S_SCAN, S_SCANW, S_SCANC,
		S_ADDSC, S_ADDW, S_ADDC, S_ADDWR,
		S_NEWW, S_OUT
	} fsm_t;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_READ = 1'b1;
endpackage

// ===== hw/rtl/feature_track_builder_core.sv =====
// Feature track builder top: sequencer, view and per-track memories, one comparator.
// Depends on ftb_pkg and ftb_ram.
// One transaction at a time: an add scans each used track, then updates the matching track
// or starts a new one. The next transaction is taken only after the result has been accepted.
// Reset clears control; only used tracks are read.
`timescale 1ns / 1ps
module feature_track_builder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// req_type[0]
	input  logic        s_tuser,
	// first_image[7:0], first_point[23:8], second_image[31:24],
	// second_point[47:32], track_sel[57:48], slot_sel[61:58], zero fill
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], track_index[12:3], view_count[17:13], consistency[26:18],
	// slot_image[34:27], slot_point[50:35], zero fill
	output logic [55:0] m_tdata
);
	import ftb_pkg::*;

	localparam int TB = $clog2(MAX_TRACKS);
	localparam int VB = $clog2(MAX_VIEWS);
	localparam int CB = $clog2(MAX_VIEWS + 1);
	localparam int UB = $clog2(MAX_TRACKS + 1);
	localparam int AB = TB + VB;

	fsm_t state_q, state_d;
	logic [IMAGE_BITS-1:0] img1_q, img2_q;
	logic [POINT_BITS-1:0] pt1_q, pt2_q;
	logic [9:0] tsel_q;
	logic [3:0] ssel_q;
	logic [UB-1:0] used_q;
	logic [TB-1:0] t_q;
	logic [CB-1:0] k_q;
	logic [CB-1:0] n_q;
	logic signed [8:0] cons_q;
	logic [1:0] newph_q;
	logic [2:0] stat_q;
	logic [9:0] oidx_q;
	logic [4:0] ovc_q;
	logic [8:0] ocons_q;
	logic [7:0] oimg_q;
	logic [15:0] opt_q;
	logic mval_q;

	// memories
	logic v_we, m_we;
	logic [AB-1:0] v_addr;
	logic [IMAGE_BITS+POINT_BITS-1:0] v_wd, v_rd;
	logic [TB-1:0] m_addr;
	logic [CB+9-1:0] m_wd, m_rd;

	ftb_ram #(.WIDTH(IMAGE_BITS + POINT_BITS), .DEPTH(MAX_TRACKS * MAX_VIEWS)) u_views (
		.clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(v_rd));
	ftb_ram #(.WIDTH(CB + 9), .DEPTH(MAX_TRACKS)) u_meta (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));

	// shared comparator
	logic [IMAGE_BITS-1:0] c_img;
	logic [POINT_BITS-1:0] c_pt;
	logic img_eq, pt_eq;
	assign img_eq = v_rd[IMAGE_BITS-1:0] == c_img;
	assign pt_eq  = v_rd[IMAGE_BITS+POINT_BITS-1:IMAGE_BITS] == c_pt;

	logic [CB-1:0] m_cnt;
	logic signed [8:0] m_cons;
	assign m_cnt  = m_rd[CB-1:0];
	assign m_cons = m_rd[CB+8:CB];

	logic [VB-1:0] k_idx, n_idx;
	assign k_idx = k_q[VB-1:0];
	assign n_idx = n_q[VB-1:0];

	// datapath control strobes
	logic ld_in, ld_n, inc_k, inc_t, set_out, clr_k;
	logic [2:0] o_stat;
	logic [9:0] o_idx;
	logic [4:0] o_vc;
	logic [8:0] o_cons;
	logic signed [8:0] cons_nx;
	logic [CB-1:0] n_nx;
	logic set_cons, set_n, used_inc;

	always_comb begin
		state_d = state_q;
		ld_in = 1'b0; ld_n = 1'b0; inc_k = 1'b0; inc_t = 1'b0; clr_k = 1'b0;
		set_out = 1'b0; o_stat = ST_READ; o_idx = 10'(t_q); o_vc = 5'(n_q);
		o_cons = cons_q; set_cons = 1'b0; cons_nx = cons_q; set_n = 1'b0;
		n_nx = n_q; used_inc = 1'b0;
		v_we = 1'b0; m_we = 1'b0;
		v_addr = {t_q, k_idx}; v_wd = {pt2_q, img2_q};
		m_addr = t_q; m_wd = {cons_q, n_q};
		c_img = img1_q; c_pt = pt1_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid && !mval_q) begin
				ld_in = 1'b1;
				state_d = (s_tuser == REQ_READ) ? S_RDREQ : S_SCAN;
			end
			S_RDREQ: begin
				m_addr = TB'(tsel_q);
				v_addr = {TB'(tsel_q), VB'(ssel_q)};
				state_d = S_RDWAIT;
			end
			S_RDWAIT: begin
				m_addr = TB'(tsel_q);
				v_addr = {TB'(tsel_q), VB'(ssel_q)};
				state_d = S_RDOUT;
			end
			S_RDOUT: begin
				set_out = 1'b1; o_stat = ST_READ; o_idx = tsel_q;
				o_vc = 5'd0; o_cons = 9'd0;
				if (32'(tsel_q) < 32'(used_q) && 32'(tsel_q) < MAX_TRACKS) begin
					o_vc = 5'(m_cnt); o_cons = m_cons;
				end
				state_d = S_OUT;
			end
			S_SCAN: begin
				clr_k = 1'b1;
				if (32'(t_q) >= 32'(used_q)) state_d = S_NEWW;
				else state_d = S_SCANW;
			end
			S_SCANW: begin
				ld_n = 1'b1; state_d = S_SCANC;
			end
			S_SCANC: begin
				// v_rd holds slot k_q-1 after first pass; handled with k_q ordering
				if (k_q != 0 && img_eq && pt_eq) begin
					clr_k = 1'b1; state_d = S_ADDSC;
				end else if (k_q >= n_q) begin
					if (32'(t_q) + 1 >= 32'(used_q)) begin
						inc_t = 1'b1; state_d = S_NEWW;
					end else begin
						inc_t = 1'b1; state_d = S_SCAN;
					end
				end else begin
					v_addr = {t_q, k_idx}; inc_k = 1'b1;
				end
			end
			S_ADDSC: begin
				if (cons_q < 0) begin
					set_out = 1'b1; o_stat = ST_IGNORED; state_d = S_OUT;
				end else begin
					v_addr = {t_q, k_idx}; inc_k = 1'b1; state_d = S_ADDW;
				end
			end
			S_ADDW: begin
				c_img = img2_q; c_pt = pt2_q;
				if (k_q != 0 && img_eq) begin
					if (pt_eq) begin
						set_cons = 1'b1;
						cons_nx = (cons_q < 9'sd255) ? cons_q + 9'sd1 : cons_q;
						state_d = S_ADDC; o_stat = ST_REPEAT;
					end else begin
						set_cons = 1'b1; cons_nx = -9'sd1;
						state_d = S_ADDC; o_stat = ST_CONFLICT;
					end
				end else if (k_q >= n_q) begin
					state_d = S_ADDWR;
				end else begin
					v_addr = {t_q, k_idx}; inc_k = 1'b1;
				end
			end
			S_ADDC: begin
				m_we = 1'b1;
				set_out = 1'b1; o_stat = (cons_q < 0) ? ST_CONFLICT : ST_REPEAT;
				state_d = S_OUT;
			end
			S_ADDWR: begin
				if (32'(n_q) >= MAX_VIEWS) begin
					set_out = 1'b1; o_stat = ST_VFULL; state_d = S_OUT;
				end else begin
					v_we = 1'b1; v_addr = {t_q, n_idx}; v_wd = {pt2_q, img2_q};
					m_we = 1'b1; m_wd = {cons_q, n_q + CB'(1)};
					set_n = 1'b1; n_nx = n_q + CB'(1);
					set_out = 1'b1; o_stat = ST_APPENDED; o_vc = 5'(n_q + CB'(1));
					state_d = S_OUT;
				end
			end
			S_NEWW: begin
				if (32'(used_q) >= MAX_TRACKS) begin
					set_out = 1'b1; o_stat = ST_TFULL; o_idx = 10'd0;
					o_vc = 5'd0; o_cons = 9'd0; state_d = S_OUT;
				end else begin
					o_idx = 10'(used_q[TB-1:0]);
					v_addr = {used_q[TB-1:0], VB'(newph_q)};
					m_addr = used_q[TB-1:0];
					if (newph_q == 2'd0) begin
						v_we = 1'b1; v_wd = {pt1_q, img1_q};
					end else if (img1_q == img2_q) begin
						m_we = 1'b1;
						cons_nx = (pt1_q == pt2_q) ? 9'sd1 : -9'sd1;
						m_wd = {cons_nx, CB'(1)};
						used_inc = 1'b1; set_out = 1'b1; o_stat = ST_NEW;
						o_vc = 5'd1; o_cons = cons_nx; state_d = S_OUT;
					end else begin
						v_we = 1'b1; v_wd = {pt2_q, img2_q};
						m_we = 1'b1; m_wd = {9'sd0, CB'(2)};
						used_inc = 1'b1; set_out = 1'b1; o_stat = ST_NEW;
						o_vc = 5'd2; o_cons = 9'sd0; state_d = S_OUT;
					end
				end
			end
			S_OUT: if (!mval_q) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			mval_q  <= 1'b0;
			t_q <= '0; k_q <= '0; newph_q <= '0;
		end else begin
			state_q <= state_d;
			if (used_inc) used_q <= used_q + UB'(1);
			if (set_out) mval_q <= 1'b1;
			else if (mval_q && m_tready) mval_q <= 1'b0;
			if (ld_in) begin
				t_q <= '0; newph_q <= '0;
			end else begin
				if (inc_t) t_q <= t_q + TB'(1);
				if (state_q == S_NEWW) newph_q <= newph_q + 2'd1;
			end
			if (clr_k) k_q <= '0;
			else if (inc_k) k_q <= k_q + CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_in) begin
			img1_q <= IMAGE_BITS'(s_tdata[7:0]);
			pt1_q  <= POINT_BITS'(s_tdata[23:8]);
			img2_q <= IMAGE_BITS'(s_tdata[31:24]);
			pt2_q  <= POINT_BITS'(s_tdata[47:32]);
			tsel_q <= s_tdata[57:48];
			ssel_q <= s_tdata[61:58];
		end
		if (ld_n) begin
			n_q <= m_cnt; cons_q <= m_cons;
		end else begin
			if (set_n) n_q <= n_nx;
			if (set_cons) cons_q <= cons_nx;
		end
		if (set_out) begin
			stat_q  <= o_stat;
			oidx_q  <= o_idx;
			ovc_q   <= o_vc;
			ocons_q <= (state_q == S_ADDC) ? cons_q : o_cons;
			if (state_q == S_RDOUT && 32'(tsel_q) < 32'(used_q)
			    && 32'(ssel_q) < 32'(m_cnt) && 32'(ssel_q) < MAX_VIEWS) begin
				oimg_q <= 8'(v_rd[IMAGE_BITS-1:0]);
				opt_q  <= 16'(v_rd[IMAGE_BITS+POINT_BITS-1:IMAGE_BITS]);
			end else begin
				oimg_q <= '0;
				opt_q  <= '0;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE) && !mval_q;
	assign m_tvalid = mval_q;
	assign m_tdata  = {5'd0, opt_q, oimg_q, ocons_q, ovc_q, oidx_q, stat_q};

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready) else $error("ready while busy");
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= MAX_TRACKS) else $error("track count overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");
endmodule

// ===== hw/rtl/ftb_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module ftb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
